// ===== hdl/tcml_pkg.sv =====
// Shared types and constants for the tile collision map lookup block.
// Used by tcml_ctrl, tcml_dp and the top level; depends on nothing else.
`default_nettype none

package tcml_pkg;

    localparam int SLOT_COUNT           = 4;
    localparam int MAP_WORDS_PER_SLOT   = 4096;
    localparam int TILE_PIXELS_PER_SLOT = 16384;

    localparam int SLOT_IW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAP_DEPTH = SLOT_COUNT * MAP_WORDS_PER_SLOT;
    localparam int PIX_DEPTH = SLOT_COUNT * TILE_PIXELS_PER_SLOT;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int PIX_AW    = $clog2(PIX_DEPTH);

    localparam logic [2:0] CMD_GET_TILE   = 3'd0;
    localparam logic [2:0] CMD_SET_TILE   = 3'd1;
    localparam logic [2:0] CMD_GET_POINT  = 3'd2;
    localparam logic [2:0] CMD_LOAD_MAP   = 3'd3;
    localparam logic [2:0] CMD_LOAD_PIXEL = 3'd4;
    localparam logic [2:0] CMD_SET_SIZE   = 3'd5;

    typedef struct packed {
        logic [2:0]         command;
        logic [1:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [15:0]        data_value;
        logic [15:0]        load_index;
        logic [15:0]        size_width;
        logic [15:0]        size_height;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] tile_value;
        logic [7:0]  point_value;
        logic        in_range;
        logic        fault;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_INDEX,
        ST_MAP_ACCESS,
        ST_MAP_WAIT,
        ST_PIX_ACCESS,
        ST_PIX_WAIT,
        ST_RESULT
    } state_t;

    // Steps of one command. The store writes of the load commands share
    // the index step: the controller never issues index for them.
    typedef struct packed {
        logic capture;
        logic locate;
        logic index;
        logic load_write;
        logic map_access;
        logic map_capture;
        logic pix_access;
        logic pix_capture;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic bad;
        logic write_cmd;
        logic map_ok;
        logic op_set;
        logic op_point;
        logic pix_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tcml_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tcml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcml_ctrl.sv =====
// Command sequencer for the tile collision map lookup block.
// Depends on tcml_pkg; drives the datapath in tcml_dp.
`default_nettype none

module tcml_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire tcml_pkg::dp_stat_t stat,
    output tcml_pkg::ctl_cmd_t      ctl
);

    tcml_pkg::state_t state_reg;
    tcml_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcml_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_stall  = (state_reg != tcml_pkg::ST_IDLE);
        unique case (state_reg)
            tcml_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = tcml_pkg::ST_LOCATE;
                end
            end
            tcml_pkg::ST_LOCATE:
            begin
                ctl.locate = 1'b1;
                if (stat.bad)
                begin
                    state_next = tcml_pkg::ST_RESULT;
                end
                else if (stat.write_cmd)
                begin
                    // loads and size writes finish in the next step
                    state_next = tcml_pkg::ST_INDEX;
                end
                else
                begin
                    state_next = tcml_pkg::ST_INDEX;
                end
            end
            tcml_pkg::ST_INDEX:
            begin
                if (stat.write_cmd)
                begin
                    ctl.load_write = 1'b1;
                    state_next     = tcml_pkg::ST_RESULT;
                end
                else
                begin
                    ctl.index  = 1'b1;
                    state_next = stat.map_ok ? tcml_pkg::ST_MAP_ACCESS : tcml_pkg::ST_RESULT;
                end
            end
            tcml_pkg::ST_MAP_ACCESS:
            begin
                ctl.map_access = 1'b1;
                state_next     = stat.op_set ? tcml_pkg::ST_RESULT : tcml_pkg::ST_MAP_WAIT;
            end
            tcml_pkg::ST_MAP_WAIT:
            begin
                ctl.map_capture = 1'b1;
                if (stat.op_point && stat.pix_ok)
                begin
                    state_next = tcml_pkg::ST_PIX_ACCESS;
                end
                else
                begin
                    state_next = tcml_pkg::ST_RESULT;
                end
            end
            tcml_pkg::ST_PIX_ACCESS:
            begin
                ctl.pix_access = 1'b1;
                state_next     = tcml_pkg::ST_PIX_WAIT;
            end
            tcml_pkg::ST_PIX_WAIT:
            begin
                ctl.pix_capture = 1'b1;
                state_next      = tcml_pkg::ST_RESULT;
            end
            tcml_pkg::ST_RESULT:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = tcml_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcml_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tcml_dp.sv =====
// Datapath: size tables, index arithmetic, map and pixel stores, output register.
// Depends on tcml_pkg and tcml_ram; steered by tcml_ctrl.
`default_nettype none

module tcml_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcml_pkg::cmd_word_t cmd_word,
    input  wire tcml_pkg::ctl_cmd_t  ctl,
    output tcml_pkg::dp_stat_t       stat,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output tcml_pkg::rsp_word_t      rsp_word
);

    // size tables
    logic [15:0] width_tab_reg  [tcml_pkg::SLOT_COUNT];
    logic [15:0] height_tab_reg [tcml_pkg::SLOT_COUNT];

    // captured command
    logic [2:0]                   command_reg;
    logic [1:0]                   slot_reg;
    logic [tcml_pkg::SLOT_IW-1:0] slot_idx_reg;
    logic                         slot_bad_reg;
    logic [31:0]                  x_reg;
    logic [31:0]                  y_reg;
    logic [15:0]                  data_reg;
    logic [15:0]                  lidx_reg;
    logic [15:0]                  size_w_reg;
    logic [15:0]                  size_h_reg;
    logic [15:0]                  width_reg;
    logic [15:0]                  height_reg;

    // index arithmetic
    logic [26:0]                 prod_reg;
    logic [12:0]                 xq_reg;
    logic [5:0]                  off_reg;
    logic [tcml_pkg::MAP_AW-1:0] map_addr_reg;
    logic [tcml_pkg::PIX_AW-1:0] pix_addr_reg;

    // result fields
    logic [15:0] tile_reg;
    logic [7:0]  point_reg;
    logic        inr_reg;
    logic        fault_reg;

    logic                 rsp_valid_reg;
    tcml_pkg::rsp_word_t  rsp_word_reg;

    logic [tcml_pkg::SLOT_IW-1:0] in_slot_idx;
    logic                         in_slot_bad;
    logic                         coord_cmd;
    logic                         in_range;
    logic [13:0]                  yq_plus;
    logic [26:0]                  prod;
    logic [27:0]                  entry;
    logic                         entry_ok;
    logic [21:0]                  pix_off;
    logic                         pix_ok;
    logic                         lidx_map_ok;
    logic                         lidx_pix_ok;
    logic [tcml_pkg::MAP_AW-1:0]  ld_map_addr;
    logic [tcml_pkg::PIX_AW-1:0]  ld_pix_addr;

    logic                         map_en;
    logic                         map_we;
    logic [tcml_pkg::MAP_AW-1:0]  map_addr;
    logic [15:0]                  map_rdata;
    logic                         pix_en;
    logic                         pix_we;
    logic [tcml_pkg::PIX_AW-1:0]  pix_addr;
    logic [7:0]                   pix_rdata;

    assign in_slot_idx = tcml_pkg::SLOT_IW'(cmd_word.slot);
    assign in_slot_bad = (32'(cmd_word.slot) >= tcml_pkg::SLOT_COUNT);

    assign coord_cmd = (command_reg == tcml_pkg::CMD_GET_TILE)
                    || (command_reg == tcml_pkg::CMD_SET_TILE)
                    || (command_reg == tcml_pkg::CMD_GET_POINT);

    assign in_range = !x_reg[31] && !y_reg[31]
                   && (x_reg < 32'(width_reg)) && (y_reg < 32'(height_reg));

    assign yq_plus = 14'(y_reg[15:3]) + 14'd1;
    assign prod    = 27'(yq_plus) * 27'(width_reg[15:3]);

    assign entry    = 28'(prod_reg) + 28'(xq_reg);
    assign entry_ok = (32'(entry) < tcml_pkg::MAP_WORDS_PER_SLOT);

    // map word read back: turn the tile number into a pixel offset
    assign pix_off = {map_rdata, 6'b000000} + 22'(off_reg);
    assign pix_ok  = (32'(pix_off) < tcml_pkg::TILE_PIXELS_PER_SLOT);

    assign lidx_map_ok = (32'(lidx_reg) < tcml_pkg::MAP_WORDS_PER_SLOT);
    assign lidx_pix_ok = (32'(lidx_reg) < tcml_pkg::TILE_PIXELS_PER_SLOT);
    assign ld_map_addr = tcml_pkg::MAP_AW'(32'(slot_reg) * tcml_pkg::MAP_WORDS_PER_SLOT
                                           + 32'(lidx_reg));
    assign ld_pix_addr = tcml_pkg::PIX_AW'(32'(slot_reg) * tcml_pkg::TILE_PIXELS_PER_SLOT
                                           + 32'(lidx_reg));

    always_comb
    begin
        stat.bad       = slot_bad_reg || (command_reg > tcml_pkg::CMD_SET_SIZE);
        stat.write_cmd = (command_reg == tcml_pkg::CMD_LOAD_MAP)
                      || (command_reg == tcml_pkg::CMD_LOAD_PIXEL)
                      || (command_reg == tcml_pkg::CMD_SET_SIZE);
        stat.map_ok    = inr_reg && entry_ok;
        stat.op_set    = (command_reg == tcml_pkg::CMD_SET_TILE);
        stat.op_point  = (command_reg == tcml_pkg::CMD_GET_POINT);
        stat.pix_ok    = pix_ok;
        stat.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // store port steering
    always_comb
    begin
        map_en   = 1'b0;
        map_we   = 1'b0;
        map_addr = map_addr_reg;
        pix_en   = 1'b0;
        pix_we   = 1'b0;
        pix_addr = pix_addr_reg;
        if (ctl.map_access)
        begin
            map_en = 1'b1;
            map_we = (command_reg == tcml_pkg::CMD_SET_TILE);
        end
        else if (ctl.load_write && (command_reg == tcml_pkg::CMD_LOAD_MAP) && lidx_map_ok)
        begin
            map_en   = 1'b1;
            map_we   = 1'b1;
            map_addr = ld_map_addr;
        end
        if (ctl.pix_access)
        begin
            pix_en = 1'b1;
        end
        else if (ctl.load_write && (command_reg == tcml_pkg::CMD_LOAD_PIXEL) && lidx_pix_ok)
        begin
            pix_en   = 1'b1;
            pix_we   = 1'b1;
            pix_addr = ld_pix_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcml_pkg::SLOT_COUNT; i++)
            begin
                width_tab_reg[i]  <= '0;
                height_tab_reg[i] <= '0;
            end
        end
        else if (ctl.load_write && (command_reg == tcml_pkg::CMD_SET_SIZE))
        begin
            width_tab_reg[slot_idx_reg]  <= size_w_reg;
            height_tab_reg[slot_idx_reg] <= size_h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            command_reg  <= cmd_word.command;
            slot_reg     <= cmd_word.slot;
            slot_idx_reg <= in_slot_idx;
            slot_bad_reg <= in_slot_bad;
            x_reg        <= cmd_word.coord_x;
            y_reg        <= cmd_word.coord_y;
            data_reg     <= cmd_word.data_value;
            lidx_reg     <= cmd_word.load_index;
            size_w_reg   <= cmd_word.size_width;
            size_h_reg   <= cmd_word.size_height;
            width_reg    <= in_slot_bad ? 16'd0 : width_tab_reg[in_slot_idx];
            height_reg   <= in_slot_bad ? 16'd0 : height_tab_reg[in_slot_idx];
            tile_reg     <= '0;
            point_reg    <= '0;
            inr_reg      <= 1'b0;
            fault_reg    <= in_slot_bad && (cmd_word.command <= tcml_pkg::CMD_SET_SIZE);
        end
        if (ctl.locate)
        begin
            inr_reg  <= coord_cmd && !slot_bad_reg && in_range;
            prod_reg <= prod;
            xq_reg   <= x_reg[15:3];
            off_reg  <= {y_reg[2:0], x_reg[2:0]};
        end
        if (ctl.index)
        begin
            map_addr_reg <= tcml_pkg::MAP_AW'(32'(slot_reg) * tcml_pkg::MAP_WORDS_PER_SLOT
                                              + 32'(entry));
            if (inr_reg && !entry_ok)
            begin
                fault_reg <= 1'b1;
            end
        end
        if (ctl.load_write)
        begin
            if ((command_reg == tcml_pkg::CMD_LOAD_MAP) && !lidx_map_ok)
            begin
                fault_reg <= 1'b1;
            end
            if ((command_reg == tcml_pkg::CMD_LOAD_PIXEL) && !lidx_pix_ok)
            begin
                fault_reg <= 1'b1;
            end
        end
        if (ctl.map_capture)
        begin
            tile_reg     <= map_rdata;
            pix_addr_reg <= tcml_pkg::PIX_AW'(32'(slot_reg) * tcml_pkg::TILE_PIXELS_PER_SLOT
                                              + 32'(pix_off));
            if ((command_reg == tcml_pkg::CMD_GET_POINT) && !pix_ok)
            begin
                fault_reg <= 1'b1;
            end
        end
        if (ctl.pix_capture)
        begin
            point_reg <= pix_rdata;
        end
        if (ctl.load_out)
        begin
            rsp_word_reg.tile_value  <= tile_reg;
            rsp_word_reg.point_value <= point_reg;
            rsp_word_reg.in_range    <= inr_reg;
            rsp_word_reg.fault       <= fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            // drop the word once taken
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    tcml_ram #(
        .WIDTH (16),
        .DEPTH (tcml_pkg::MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .en    (map_en),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (data_reg),
        .rdata (map_rdata)
    );

    tcml_ram #(
        .WIDTH (8),
        .DEPTH (tcml_pkg::PIX_DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .en    (pix_en),
        .we    (pix_we),
        .addr  (pix_addr),
        .wdata (data_reg[7:0]),
        .rdata (pix_rdata)
    );

endmodule

`default_nettype wire

// ===== hdl/tile_collision_map_lookup_top.sv =====
// Tile collision map lookup: one command word in, one result word out per command.
// get_point runs locate, index, a map read and a pixel read; get_tile stops
// after the map read, set_tile after the map write; loads and set_size do one
// store write; a bad slot or an unused code goes straight to the result. One
// command is worked on at a time; get_point is bounded by the chain of two
// dependent registered reads (map word, then tile pixel) behind the index
// multiply. The output register frees the command side: the next command is
// accepted as soon as the previous result is loaded into it. Stores need no
// clearing after reset; only locations written since reset may be read.
// Depends on tcml_pkg, tcml_ctrl, tcml_dp and tcml_ram.
`default_nettype none

module tile_collision_map_lookup_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire tcml_pkg::cmd_word_t cmd_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output tcml_pkg::rsp_word_t      rsp_word
);

    tcml_pkg::ctl_cmd_t ctl;
    tcml_pkg::dp_stat_t stat;

    tcml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    tcml_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire
